FILE: hw/rtl/sha256sh_pkg.sv
package sha256sh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_word_t;

    // Index 0 is H0 / a.
    typedef logic [7:0][31:0] hash_t;

    // Sequencer to core controls.
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       load;
        logic       round;
        logic [5:0] round_idx;
        logic       fold;
        logic       reinit;
    } core_ctrl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam hash_t INITIAL_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_const = k;
    endfunction

endpackage

FILE: hw/rtl/sha256sh_core.sv
module sha256sh_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256sh_pkg::core_ctrl_t ctrl,
    output sha256sh_pkg::hash_t     hash
);

    // Schedule window: w_reg[15] is the oldest word (W[t] during rounds).
    // Bytes shift in at the bottom, so it doubles as the block buffer.
    logic [15:0][31:0]   w_reg;
    logic [15:0][31:0]   w_next;
    sha256sh_pkg::hash_t v_reg;
    sha256sh_pkg::hash_t v_next;
    sha256sh_pkg::hash_t h_reg;
    sha256sh_pkg::hash_t h_next;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;
    logic [31:0] new_w;

    always_comb
    begin
        ch_val  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj_val = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + sha256sh_pkg::big_sigma1(v_reg[4]) + ch_val
            + sha256sh_pkg::round_const(ctrl.round_idx) + w_reg[15];
        t2 = sha256sh_pkg::big_sigma0(v_reg[0]) + maj_val;
        new_w = sha256sh_pkg::small_sigma1(w_reg[1]) + w_reg[6]
            + sha256sh_pkg::small_sigma0(w_reg[14]) + w_reg[15];
    end

    always_comb
    begin
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        if (ctrl.push)
        begin
            // Shift the window up one byte; the oldest byte drops off the top.
            w_next = 512'({w_reg, ctrl.push_data});
        end
        if (ctrl.load)
        begin
            v_next = h_reg;
        end
        if (ctrl.round)
        begin
            w_next = {w_reg[14:0], new_w};
            v_next = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
        end
        if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
        if (ctrl.reinit)
        begin
            h_next = sha256sh_pkg::INITIAL_H;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha256sh_pkg::INITIAL_H;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    assign hash = h_reg;

endmodule

FILE: hw/rtl/sha256stream_hasher_top_placeholder.sv
module sha256sh_outreg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  sha256sh_pkg::out_word_t load_data,
    output logic                    free,
    output logic                    digest_valid,
    input  logic                    digest_ready,
    output sha256sh_pkg::out_word_t digest
);

    logic                    valid_reg;
    logic                    valid_next;
    sha256sh_pkg::out_word_t data_reg;

    // Refill in the same cycle the held word leaves.
    assign free = !valid_reg || digest_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (digest_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign digest_valid = valid_reg;
    assign digest = data_reg;

endmodule

FILE: hw/rtl/sha256_stream_hasher_top.sv
// Channel  | Signals                           | Word
// ---------+-----------------------------------+----------------------------------------
// item     | item_valid, item_ready, item      | data_byte, byte_present, end_of_message
// digest   | digest_valid, digest_ready, digest| digest_word, word_index, last_word
//
// A byte word shifts its byte into the block buffer; the 64th byte of a block adds the
// rounds and a fold, all through the single shared round unit.
// An end word adds 9 to 72 padding bytes, one or two compressions, and the hand-out of
// the four digest words.
// item_ready is high only while the sequencer idles; the last digest word may still
// wait in the output register while the next message starts.
// rst_n clears the sequencer and the bit count and sets the chaining words to their initial values at once.
module sha256_stream_hasher_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  sha256sh_pkg::in_word_t  item,
    output logic                    digest_valid,
    input  logic                    digest_ready,
    output sha256sh_pkg::out_word_t digest
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_FOLD   = 3'd3;
    localparam logic [2:0] ST_DIGEST = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] bit_count_reg;
    logic [63:0] bit_count_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic        pad_active_reg;
    logic        pad_active_next;
    logic        first_reg;
    logic        first_next;
    logic        len_phase_reg;
    logic        len_phase_next;
    logic [2:0]  len_idx_reg;
    logic [2:0]  len_idx_next;
    logic        final_reg;
    logic        final_next;
    logic [1:0]  word_reg;
    logic [1:0]  word_next;

    sha256sh_pkg::core_ctrl_t ctrl;
    sha256sh_pkg::hash_t      hash;
    sha256sh_pkg::out_word_t  out_data;
    logic                     out_load;
    logic                     out_free;
    logic                     len_emit;

    assign item_ready = (state_reg == ST_IDLE);
    assign len_emit = !first_reg && (len_phase_reg || (fill_reg == sha256sh_pkg::LEN_POS));

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        bit_count_next  = bit_count_reg;
        round_next      = round_reg;
        pad_active_next = pad_active_reg;
        first_next      = first_reg;
        len_phase_next  = len_phase_reg;
        len_idx_next    = len_idx_reg;
        final_next      = final_reg;
        word_next       = word_reg;
        ctrl            = '0;
        ctrl.round_idx  = round_reg;
        out_load        = 1'b0;
        out_data.digest_word = {hash[{word_reg, 1'b0}], hash[{word_reg, 1'b1}]};
        out_data.word_index  = word_reg;
        out_data.last_word   = (word_reg == 2'd3);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pad_active_next = item.end_of_message;
                    first_next = 1'b1;
                    if (item.byte_present)
                    begin
                        ctrl.push = 1'b1;
                        ctrl.push_data = item.data_byte;
                        fill_next = fill_reg + 6'd1;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (item.byte_present && fill_reg == sha256sh_pkg::LAST_POS)
                    begin
                        ctrl.load = 1'b1;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                    else if (item.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                ctrl.push = 1'b1;
                fill_next = fill_reg + 6'd1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    ctrl.push_data = sha256sh_pkg::PAD_BYTE;
                end
                else if (len_emit)
                begin
                    ctrl.push_data = bit_count_reg[{len_idx_reg, 3'b000} +: 8];
                    len_phase_next = 1'b1;
                    len_idx_next = len_idx_reg - 3'd1;
                    if (len_idx_reg == 3'd0)
                    begin
                        final_next = 1'b1;
                        pad_active_next = 1'b0;
                    end
                end
                else
                begin
                    ctrl.push_data = 8'h00;
                end
                if (fill_reg == sha256sh_pkg::LAST_POS)
                begin
                    ctrl.load = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == sha256sh_pkg::LAST_POS)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                priority if (final_reg)
                begin
                    word_next = '0;
                    state_next = ST_DIGEST;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIGEST:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    word_next = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                    begin
                        // Hand out the last word and start over from the initial values.
                        ctrl.reinit = 1'b1;
                        bit_count_next = '0;
                        final_next = 1'b0;
                        len_phase_next = 1'b0;
                        len_idx_next = 3'd7;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            bit_count_reg  <= '0;
            round_reg      <= '0;
            pad_active_reg <= 1'b0;
            first_reg      <= 1'b0;
            len_phase_reg  <= 1'b0;
            len_idx_reg    <= 3'd7;
            final_reg      <= 1'b0;
            word_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bit_count_reg  <= bit_count_next;
            round_reg      <= round_next;
            pad_active_reg <= pad_active_next;
            first_reg      <= first_next;
            len_phase_reg  <= len_phase_next;
            len_idx_reg    <= len_idx_next;
            final_reg      <= final_next;
            word_reg       <= word_next;
        end
    end

    sha256sh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .hash  (hash)
    );

    sha256sh_outreg u_outreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .load_data    (out_data),
        .free         (out_free),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

FILE: sim/sha256_stream_hasher_checker.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_ready,
    input  sha256sh_pkg::in_word_t  item,
    input  logic                    digest_valid,
    input  logic                    digest_ready,
    input  sha256sh_pkg::out_word_t digest,
    output int                      fail_count,
    output int                      words_due
);

    localparam logic [7:0] MARKER_BYTE = 8'h80;
    localparam int         LENGTH_START = 56;
    localparam int         MAX_REPORTS = 10;

    localparam logic [0:7][31:0] START_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]             chain [8];
    logic [7:0]              msg_block [64];
    logic [63:0]             bit_total;
    sha256sh_pkg::out_word_t digest_due [$];
    int                      errs = 0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function automatic void start_message();
        for (int i = 0; i < 8; i++)
            chain[i] = START_H[i];
        bit_total = '0;
    endfunction

    function automatic void hash_item(input sha256sh_pkg::in_word_t it);
        int                      pos;
        logic [63:0]             len;
        sha256sh_pkg::out_word_t rec;
        if (it.byte_present)
        begin
            pos = int'(bit_total[8:3]);
            msg_block[pos] = it.data_byte;
            bit_total = bit_total + 64'd8;
            if (pos == 63)
                compress_block();
        end
        if (it.end_of_message)
        begin
            len = bit_total;
            pos = int'(len[8:3]);
            msg_block[pos] = MARKER_BYTE;
            for (int i = pos + 1; i < 64; i++)
                msg_block[i] = 8'h00;
            // no room for the length field: spill into a second block
            if (pos >= LENGTH_START)
            begin
                compress_block();
                for (int i = 0; i < LENGTH_START; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[63-i] = len[8*i +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                rec.digest_word = {chain[2*k], chain[2*k+1]};
                rec.word_index = 2'(k);
                rec.last_word = (k == 3);
                digest_due.push_back(rec);
            end
            start_message();
        end
    endfunction

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        errs++;
        if (errs <= MAX_REPORTS)
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sha256sh_pkg::out_word_t want;
        if (!rst_n)
        begin
            start_message();
            digest_due.delete();
            words_due <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (digest_due.size() == 0)
                begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("%0t ns: unexpected digest word %h index %0d last %b",
                                 $time, digest.digest_word, digest.word_index,
                                 digest.last_word);
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (digest.digest_word !== want.digest_word)
                        flag("digest_word", want.digest_word, digest.digest_word);
                    if (digest.word_index !== want.word_index)
                        flag("word_index", 64'(want.word_index), 64'(digest.word_index));
                    if (digest.last_word !== want.last_word)
                        flag("last_word", 64'(want.last_word), 64'(digest.last_word));
                end
            end
            if (item_valid && item_ready)
                hash_item(item);
            words_due <= digest_due.size();
            fail_count <= errs;
        end
    end

endmodule

FILE: sim/sha256_stream_hasher_top_test.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_top_test;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_ready;
    sha256sh_pkg::in_word_t  item = '0;
    logic                    digest_valid;
    logic                    digest_ready = 1'b0;
    sha256sh_pkg::out_word_t digest;
    int                      fail_count;
    int                      words_due;

    int        idle_pct = 0;
    int        stall_pct = 0;
    int        items_sent = 0;

    sha256_stream_hasher_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    sha256_stream_hasher_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            digest_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic put_word(input logic [7:0] b, input logic has, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = '{data_byte: b, byte_present: has, end_of_message: fin};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // drop valid and hold off until every digest word is out
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int len, input bit end_alone);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                put_word(8'($urandom_range(255)), 1'b0, 1'b0);
            put_word(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_alone);
        end
        if (len == 0 || end_alone)
            put_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // favor lengths around the padding boundaries
    function automatic int pick_length();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(20);
            3:       return $urandom_range(52, 60);
            4:       return $urandom_range(61, 67);
            5:       return $urandom_range(117, 129);
            6:       return $urandom_range(150, 200);
            default: return $urandom_range(1, 50);
        endcase
    endfunction

    initial
    begin
        int target;
        int len;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        put_word(8'hA5, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b1);
        put_word(8'h61, 1'b1, 1'b0);
        put_word(8'h62, 1'b1, 1'b0);
        put_word(8'h63, 1'b1, 1'b1);
        put_word(8'h00, 1'b1, 1'b1);
        put_word(8'hFF, 1'b1, 1'b1);
        put_word(8'h5A, 1'b1, 1'b0);
        put_word(8'hFF, 1'b0, 1'b1);
        put_word(8'hFF, 1'b0, 1'b0);
        put_word(8'hFF, 1'b0, 1'b1);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'h80, 1'b1, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            target = items_sent + 115;
            while (items_sent < target)
            begin
                // trim the last message so the phase ends near its item budget
                len = pick_length();
                if (len > target - items_sent)
                    len = target - items_sent;
                send_message(len, $urandom_range(3) == 0);
            end
            drain();
        end

        stall_pct = 0;
        repeat (300) @(posedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sha256sh_pkg.sv
hw/rtl/sha256sh_core.sv
hw/rtl/sha256stream_hasher_top_placeholder.sv
hw/rtl/sha256_stream_hasher_top.sv
sim/sha256_stream_hasher_checker.sv
sim/sha256_stream_hasher_top_test.sv
